FILE: src/lprd_pkg.sv
// Shared types and constants of the length-prefixed request deframer.
`default_nettype none
package lprd_pkg;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [31:0] MAX_MSG_RESET  = 32'd33554432;
  localparam logic [20:0] MAX_ARGS_RESET = 21'd200000;

  localparam logic [2:0] ADDR_MAX_MSG  = 3'd0;
  localparam logic [2:0] ADDR_MAX_ARGS = 3'd4;

  typedef enum logic [2:0] {
    PH_FRAME_LEN,
    PH_ARG_COUNT,
    PH_ARG_LEN,
    PH_ARG_DATA,
    PH_FAILED
  } lprd_phase_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_TOO_LONG,
    ST_TOO_MANY,
    ST_OVERRUN,
    ST_TRAILING
  } lprd_status_t;

  typedef enum logic [3:0] {
    EV_NONE,
    EV_PAYLOAD,
    EV_ARG_END,
    EV_ARG_LEN,
    EV_FRAME_OK,
    EV_COUNT,
    EV_FAIL_LONG,
    EV_FAIL_MANY,
    EV_FAIL_HDR_OVR,
    EV_FAIL_ARG_OVR
  } lprd_evt_t;

  typedef struct packed {
    logic [31:0] max_msg;
    logic [20:0] max_args;
  } lprd_cfg_t;

  typedef struct packed {
    logic         has_payload;
    logic [7:0]   payload_byte;
    logic [19:0]  argument_index;
    logic         argument_end;
    logic         message_end;
    lprd_status_t status;
  } lprd_res_t;

  typedef struct packed {
    logic            full;
    logic            empty;
    logic [Q_AW:0]   count;
  } lprd_qstat_t;

endpackage
`default_nettype wire

FILE: src/lprd_front.sv
// Front end: assembles length fields, tracks the body and classifies each byte.
`default_nettype none
module lprd_front import lprd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_acc,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_new_conn,
  input  wire lprd_cfg_t   cfg,
  output logic             res_valid,
  output lprd_res_t        res,
  output lprd_phase_t      phase
);

  lprd_phase_t phase_r, phase_nxt;
  logic [23:0] shift_r, shift_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [31:0] body_r, body_nxt;
  logic [20:0] args_r, args_nxt;
  logic [31:0] abytes_r, abytes_nxt;
  logic [19:0] cur_r, cur_nxt;

  lprd_phase_t ph;
  logic [1:0]  pos;
  logic [31:0] body, body_n, abytes, abytes_n, v;
  logic [20:0] args, args_a;
  logic [19:0] cur;
  logic        fld, fdone, aa_done, aa_trail, aa_ovr;
  lprd_evt_t   evt;

  // Decode: a new connection clears the parse state ahead of this byte
  always_comb begin
    ph     = in_new_conn ? PH_FRAME_LEN : phase_r;
    pos    = in_new_conn ? 2'd0  : pos_r;
    body   = in_new_conn ? 32'd0 : body_r;
    args   = in_new_conn ? 21'd0 : args_r;
    abytes = in_new_conn ? 32'd0 : abytes_r;
    cur    = in_new_conn ? 20'd0 : cur_r;
    fld    = (ph == PH_FRAME_LEN) || (ph == PH_ARG_COUNT) || (ph == PH_ARG_LEN);
    fdone  = fld && (pos == 2'd3);
    v      = {in_byte, shift_r};
    body_n   = body;
    abytes_n = abytes;
    case (ph)
      PH_ARG_COUNT, PH_ARG_LEN: begin
        body_n = body - 32'd1;
      end
      PH_ARG_DATA: begin
        body_n   = (body != 32'd0) ? body - 32'd1 : body;
        abytes_n = (abytes != 32'd0) ? abytes - 32'd1 : abytes;
      end
      default: begin
        body_n = body;
      end
    endcase
    evt = EV_NONE;
    case (ph)
      PH_FRAME_LEN: begin
        if (fdone) begin
          if (v > cfg.max_msg)  evt = EV_FAIL_LONG;
          else if (v < 32'd4)   evt = EV_FAIL_HDR_OVR;
          else                  evt = EV_FRAME_OK;
        end
      end
      PH_ARG_COUNT: begin
        if (fdone) begin
          if (v > {11'd0, cfg.max_args}) evt = EV_FAIL_MANY;
          else                           evt = EV_COUNT;
        end
      end
      PH_ARG_LEN: begin
        if (fdone) begin
          if (v > body_n)       evt = EV_FAIL_ARG_OVR;
          else if (v == 32'd0)  evt = EV_ARG_END;
          else                  evt = EV_ARG_LEN;
        end
      end
      PH_ARG_DATA: begin
        evt = (abytes_n == 32'd0) ? EV_ARG_END : EV_PAYLOAD;
      end
      default: begin
        evt = EV_NONE;
      end
    endcase
    args_a   = (evt == EV_COUNT) ? v[20:0] : args - 21'd1;
    aa_done  = (args_a == 21'd0) && (body_n == 32'd0);
    aa_trail = (args_a == 21'd0) && (body_n != 32'd0);
    aa_ovr   = (args_a != 21'd0) && (body_n < 32'd4);
  end

  // Next state
  always_comb begin
    phase_nxt  = ph;
    pos_nxt    = fld ? pos + 2'd1 : pos;
    shift_nxt  = shift_r;
    body_nxt   = body_n;
    args_nxt   = args;
    abytes_nxt = abytes_n;
    cur_nxt    = cur;
    if (fld) begin
      case (pos)
        2'd0:    shift_nxt = {16'd0, in_byte};
        2'd1:    shift_nxt = {8'd0, in_byte, shift_r[7:0]};
        2'd2:    shift_nxt = {in_byte, shift_r[15:0]};
        default: shift_nxt = shift_r;
      endcase
    end
    case (evt)
      EV_FAIL_LONG, EV_FAIL_MANY, EV_FAIL_HDR_OVR, EV_FAIL_ARG_OVR: begin
        phase_nxt = PH_FAILED;
      end
      EV_FRAME_OK: begin
        body_nxt  = v;
        phase_nxt = PH_ARG_COUNT;
      end
      EV_ARG_LEN: begin
        abytes_nxt = v;
        phase_nxt  = PH_ARG_DATA;
      end
      EV_COUNT, EV_ARG_END: begin
        args_nxt = args_a;
        cur_nxt  = (evt == EV_COUNT) ? 20'd0 : cur + 20'd1;
        if (aa_done)                phase_nxt = PH_FRAME_LEN;
        else if (aa_trail || aa_ovr) phase_nxt = PH_FAILED;
        else                        phase_nxt = PH_ARG_LEN;
      end
      default: begin
        phase_nxt = ph;
      end
    endcase
  end

  // Result
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    case (evt)
      EV_FAIL_LONG: begin
        res_valid       = 1'b1;
        res.message_end = 1'b1;
        res.status      = ST_TOO_LONG;
      end
      EV_FAIL_MANY: begin
        res_valid       = 1'b1;
        res.message_end = 1'b1;
        res.status      = ST_TOO_MANY;
      end
      EV_FAIL_HDR_OVR: begin
        res_valid       = 1'b1;
        res.message_end = 1'b1;
        res.status      = ST_OVERRUN;
      end
      EV_FAIL_ARG_OVR: begin
        res_valid          = 1'b1;
        res.argument_index = cur;
        res.message_end    = 1'b1;
        res.status         = ST_OVERRUN;
      end
      EV_COUNT: begin
        res_valid       = aa_done || aa_trail || aa_ovr;
        res.message_end = res_valid;
        res.status      = aa_trail ? ST_TRAILING : (aa_ovr ? ST_OVERRUN : ST_OK);
      end
      EV_ARG_END: begin
        res_valid          = 1'b1;
        res.has_payload    = (ph == PH_ARG_DATA);
        res.payload_byte   = (ph == PH_ARG_DATA) ? in_byte : 8'd0;
        res.argument_index = cur;
        res.argument_end   = 1'b1;
        res.message_end    = aa_done || aa_trail || aa_ovr;
        res.status         = aa_trail ? ST_TRAILING : (aa_ovr ? ST_OVERRUN : ST_OK);
      end
      EV_PAYLOAD: begin
        res_valid          = 1'b1;
        res.has_payload    = 1'b1;
        res.payload_byte   = in_byte;
        res.argument_index = cur;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FRAME_LEN;
      shift_r  <= '0;
      pos_r    <= '0;
      body_r   <= '0;
      args_r   <= '0;
      abytes_r <= '0;
      cur_r    <= '0;
    end else if (in_acc) begin
      phase_r  <= phase_nxt;
      shift_r  <= shift_nxt;
      pos_r    <= pos_nxt;
      body_r   <= body_nxt;
      args_r   <= args_nxt;
      abytes_r <= abytes_nxt;
      cur_r    <= cur_nxt;
    end
  end

  assign phase = phase_r;

endmodule
`default_nettype wire

FILE: src/lprd_queue.sv
// Short result queue between the front end and the output stage.
`default_nettype none
module lprd_queue import lprd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire lprd_res_t push_data,
  input  wire logic  pop,
  output logic       pop_valid,
  output lprd_res_t  pop_data,
  output lprd_qstat_t stat
);

  lprd_res_t         mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]     count_r, count_nxt;
  logic              do_push, do_pop;

  always_comb begin
    do_push    = push && (count_r != (Q_AW+1)'(Q_DEPTH));
    do_pop     = pop && (count_r != '0);
    wr_ptr_nxt = do_push ? wr_ptr_r + Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + Q_AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop)      count_nxt = count_r + (Q_AW+1)'(1);
    else if (!do_push && do_pop) count_nxt = count_r - (Q_AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;

endmodule
`default_nettype wire

FILE: src/lprd_back.sv
// Back end: output register that packs results onto the result stream.
`default_nettype none
module lprd_back import lprd_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         q_valid,
  input  wire lprd_res_t    q_data,
  output logic              q_pop,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [31:0]       out_tdata,  // payload_byte, argument_index, argument_end, status
  output logic              out_tuser,  // has_payload
  output logic              out_tlast   // message_end
);

  logic      valid_r, valid_nxt;
  lprd_res_t data_r;

  always_comb begin
    q_pop     = q_valid && (!valid_r || out_tready);
    valid_nxt = q_pop ? 1'b1 : (valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r <= q_data;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {data_r.status, data_r.argument_end, data_r.argument_index,
                       data_r.payload_byte};
  assign out_tuser  = data_r.has_payload;
  assign out_tlast  = data_r.message_end;

endmodule
`default_nettype wire

FILE: src/length_prefixed_request_deframer.sv
// Top level: config registers, front end, result queue and output stage.
// Path: a result is written into the queue when its byte transfers, then moved into
// the output register that drives out_tvalid.
// Throughput: one byte per cycle; in_tready falls only when the four-entry queue
// is full because the output side is stalled.
// Reset: synchronous, active low; clears parse state, queue and output valid and
// loads the limits with their reset values.
`default_nettype none
module length_prefixed_request_deframer import lprd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // stream_byte
  input  wire logic        in_tuser,   // new_connection
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // payload_byte, argument_index, argument_end, status
  output logic             out_tuser,  // has_payload
  output logic             out_tlast,  // message_end
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  lprd_cfg_t   cfg_r, cfg_nxt;
  logic        cfg_wr, in_acc, f_valid, q_valid, q_pop;
  lprd_res_t   f_res, q_data;
  lprd_phase_t f_phase;
  lprd_qstat_t qstat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_paddr)
        ADDR_MAX_MSG:  cfg_nxt.max_msg  = cfg_pwdata;
        ADDR_MAX_ARGS: cfg_nxt.max_args = cfg_pwdata[20:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
    case (cfg_paddr)
      ADDR_MAX_MSG:  cfg_prdata = cfg_r.max_msg;
      ADDR_MAX_ARGS: cfg_prdata = {11'd0, cfg_r.max_args};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_msg  <= MAX_MSG_RESET;
      cfg_r.max_args <= MAX_ARGS_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_tready = !qstat.full;
  assign in_acc    = in_tvalid && in_tready;

  lprd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_acc      (in_acc),
    .in_byte     (in_tdata),
    .in_new_conn (in_tuser),
    .cfg         (cfg_r),
    .res_valid   (f_valid),
    .res         (f_res),
    .phase       (f_phase)
  );

  lprd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc && f_valid),
    .push_data (f_res),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data),
    .stat      (qstat)
  );

  lprd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && f_valid && f_res.message_end && f_res.status != ST_OK)
      |=> (f_phase == PH_FAILED))
    else $error("error result did not leave the parser failed");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (qstat.count <= Q_DEPTH) && (qstat.empty == !q_valid))
    else $error("queue occupancy out of range");

  a_payload_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser && !out_tdata[28]) |-> !out_tlast)
    else $error("mid-argument payload marked as message end");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (qstat.full && q_pop) |=> !qstat.full)
    else $error("queue stayed full after a pop with no push");

endmodule
`default_nettype wire

FILE: tb/length_prefixed_request_deframer_tb.sv
// Testbench for the length-prefixed request deframer: directed and random byte streams.
`timescale 1ns / 1ps

module length_prefixed_request_deframer_tb import lprd_pkg::*; ();

  typedef enum int {
    MUTATE_NONE,
    MUTATE_BODY_SHORT,
    MUTATE_BODY_LONG,
    MUTATE_COUNT,
    MUTATE_ARG_LEN,
    MUTATE_TRUNCATE,
    MUTATE_NOISE
  } mutation_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;   // stream_byte
  logic        in_tuser = 1'b0;   // new_connection
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // payload_byte, argument_index, argument_end, status
  logic        out_tuser;         // has_payload
  logic        out_tlast;         // message_end
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  length_prefixed_request_deframer u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #6 clk = ~clk;

  // parser mirror
  lprd_phase_t ph;
  logic [31:0] word_acc;
  logic [1:0]  word_pos;
  logic [31:0] body_left;
  logic [20:0] args_left;
  logic [31:0] arg_left;
  logic [19:0] arg_idx;
  logic [31:0] lim_msg;
  logic [20:0] lim_args;

  lprd_res_t   pending_events[$];
  logic [7:0]  frame_q[$];

  int  mismatches = 0;
  int  bytes_sent = 0;
  int  results_checked = 0;
  int  message_ends = 0;
  int  cfg_writes = 0;
  bit  feed_throttle = 1'b1;
  bit  sink_throttle = 1'b1;
  int  ready_hold = 0;

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 30)
      $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  function automatic void reset_parse();
    ph        = PH_FRAME_LEN;
    word_acc  = '0;
    word_pos  = '0;
    body_left = '0;
    args_left = '0;
    arg_left  = '0;
    arg_idx   = '0;
  endfunction

  function automatic bit gather_byte(input logic [7:0] b);
    if (word_pos == 2'd0)
      word_acc = {24'd0, b};
    else
      word_acc = word_acc | ({24'd0, b} << (8 * word_pos));
    word_pos = word_pos + 2'd1;
    return word_pos == 2'd0;
  endfunction

  function automatic lprd_res_t make_event(input bit has, input logic [7:0] b,
                                           input logic [19:0] idx, input bit aend,
                                           input bit mend, input lprd_status_t st);
    lprd_res_t r;
    r.has_payload    = has;
    r.payload_byte   = b;
    r.argument_index = idx;
    r.argument_end   = aend;
    r.message_end    = mend;
    r.status         = st;
    return r;
  endfunction

  function automatic bit reject(input lprd_status_t st, input logic [19:0] idx,
                                output lprd_res_t r);
    ph = PH_FAILED;
    r  = make_event(1'b0, 8'd0, idx, 1'b0, 1'b1, st);
    return 1'b1;
  endfunction

  function automatic bit close_or_continue(input bit aend, input bit has,
                                           input logic [7:0] b, input logic [19:0] idx,
                                           output lprd_res_t r);
    r = '0;
    if (args_left == 21'd0) begin
      if (body_left != 32'd0) begin
        ph = PH_FAILED;
        r  = make_event(has, b, idx, aend, 1'b1, ST_TRAILING);
        return 1'b1;
      end
      ph = PH_FRAME_LEN;
      r  = make_event(has, b, idx, aend, 1'b1, ST_OK);
      return 1'b1;
    end
    if (body_left < 32'd4) begin
      ph = PH_FAILED;
      r  = make_event(has, b, idx, aend, 1'b1, ST_OVERRUN);
      return 1'b1;
    end
    ph = PH_ARG_LEN;
    if (aend)
      r = make_event(has, b, idx, 1'b1, 1'b0, ST_OK);
    return aend;
  endfunction

  function automatic bit complete_argument(input bit has, input logic [7:0] b,
                                           output lprd_res_t r);
    logic [19:0] idx;
    idx       = arg_idx;
    args_left = args_left - 21'd1;
    arg_idx   = arg_idx + 20'd1;
    return close_or_continue(1'b1, has, b, idx, r);
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input bit nc, output lprd_res_t r);
    r = '0;
    if (nc)
      reset_parse();
    case (ph)
      PH_FRAME_LEN: begin
        if (!gather_byte(b))
          return 1'b0;
        if (word_acc > lim_msg)
          return reject(ST_TOO_LONG, 20'd0, r);
        body_left = word_acc;
        if (word_acc < 32'd4)
          return reject(ST_OVERRUN, 20'd0, r);
        ph = PH_ARG_COUNT;
        return 1'b0;
      end
      PH_ARG_COUNT: begin
        body_left = body_left - 32'd1;
        if (!gather_byte(b))
          return 1'b0;
        if (word_acc > {11'd0, lim_args})
          return reject(ST_TOO_MANY, 20'd0, r);
        args_left = word_acc[20:0];
        arg_idx   = '0;
        return close_or_continue(1'b0, 1'b0, 8'd0, 20'd0, r);
      end
      PH_ARG_LEN: begin
        body_left = body_left - 32'd1;
        if (!gather_byte(b))
          return 1'b0;
        if (word_acc > body_left)
          return reject(ST_OVERRUN, arg_idx, r);
        if (word_acc == 32'd0)
          return complete_argument(1'b0, 8'd0, r);
        arg_left = word_acc;
        ph       = PH_ARG_DATA;
        return 1'b0;
      end
      PH_ARG_DATA: begin
        if (body_left != 32'd0)
          body_left = body_left - 32'd1;
        if (arg_left != 32'd0)
          arg_left = arg_left - 32'd1;
        if (arg_left == 32'd0)
          return complete_argument(1'b1, b, r);
        r = make_event(1'b1, b, arg_idx, 1'b0, 1'b0, ST_OK);
        return 1'b1;
      end
      default: begin
        ph = PH_FAILED;
        return 1'b0;
      end
    endcase
    return 1'b0;
  endfunction

  // output stall bursts
  always @(posedge clk) begin
    if (!sink_throttle) begin
      out_tready <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold = ready_hold - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= 35);
      ready_hold = $urandom_range(0, 10);
    end
  end

  always @(posedge clk) begin : check_results
    lprd_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_events.size() == 0) begin
        log_mismatch($sformatf("transfer with nothing awaited: tdata %h tuser %b tlast %b",
                               out_tdata, out_tuser, out_tlast));
      end else begin
        want = pending_events.pop_front();
        results_checked++;
        if (want.message_end)
          message_ends++;
        if (out_tuser !== want.has_payload)
          log_mismatch($sformatf("has_payload %b, want %b", out_tuser, want.has_payload));
        if (out_tdata[7:0] !== want.payload_byte)
          log_mismatch($sformatf("payload_byte %h, want %h", out_tdata[7:0],
                                 want.payload_byte));
        if (out_tdata[27:8] !== want.argument_index)
          log_mismatch($sformatf("argument_index %0d, want %0d", out_tdata[27:8],
                                 want.argument_index));
        if (out_tdata[28] !== want.argument_end)
          log_mismatch($sformatf("argument_end %b, want %b", out_tdata[28],
                                 want.argument_end));
        if (out_tlast !== want.message_end)
          log_mismatch($sformatf("message_end %b, want %b", out_tlast, want.message_end));
        if (out_tdata[31:29] !== want.status)
          log_mismatch($sformatf("status %0d, want %s", out_tdata[31:29],
                                 want.status.name()));
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit nc);
    int        gap;
    lprd_res_t r;
    if (feed_throttle && $urandom_range(0, 99) < 12) begin
      gap = $urandom_range(1, 11);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= nc;
    do @(posedge clk); while (!in_tready);
    if (parse_byte(b, nc, r))
      pending_events.insert(pending_events.size(), r);
    bytes_sent++;
  endtask

  function automatic void push_byte(input logic [7:0] b);
    frame_q.insert(frame_q.size(), b);
  endfunction

  function automatic void push_word(input logic [31:0] v);
    push_byte(v[7:0]);
    push_byte(v[15:8]);
    push_byte(v[23:16]);
    push_byte(v[31:24]);
  endfunction

  task automatic send_frame(input bit nc);
    foreach (frame_q[i])
      send_byte(frame_q[i], nc && (i == 0));
    frame_q.delete();
  endtask

  task automatic settle_parser();
    in_tvalid <= 1'b0;
    while (pending_events.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic check_limit(input logic [2:0] addr, input logic [31:0] want);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want)
      log_mismatch($sformatf("register at %0d reads %h, want %h", addr, cfg_prdata, want));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_limit(input logic [2:0] addr, input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_writes++;
    if (addr == ADDR_MAX_MSG) begin
      lim_msg = value;
      check_limit(addr, value);
    end else begin
      lim_args = value[20:0];
      check_limit(addr, {11'd0, value[20:0]});
    end
  endtask

  task automatic apply_limits(input logic [31:0] msg_max, input logic [20:0] args_max);
    settle_parser();
    set_limit(ADDR_MAX_MSG, msg_max);
    set_limit(ADDR_MAX_ARGS, {11'd0, args_max});
  endtask

  task automatic test_register_access();
    check_limit(ADDR_MAX_MSG, MAX_MSG_RESET);
    check_limit(ADDR_MAX_ARGS, {11'd0, MAX_ARGS_RESET});
    set_limit(ADDR_MAX_MSG, 32'd0);
    set_limit(ADDR_MAX_MSG, 32'hFFFF_FFFF);
    set_limit(ADDR_MAX_ARGS, 32'd0);
    set_limit(ADDR_MAX_ARGS, 32'd1048576);
  endtask

  task automatic test_frame_length_checks();
    apply_limits(32'd16, MAX_ARGS_RESET);
    // body exactly at the limit
    push_word(32'd16); push_word(32'd1); push_word(32'd8);
    push_byte(8'h00); push_byte(8'hFF); push_byte(8'h00); push_byte(8'hFF);
    push_byte(8'hAA); push_byte(8'h55); push_byte(8'hFF); push_byte(8'h00);
    send_frame(1'b1);
    push_word(32'd17);
    send_frame(1'b1);
    push_word(32'd16); push_word(32'd0);
    send_frame(1'b1);
    push_word(32'd3);
    send_frame(1'b1);
    apply_limits(32'd0, MAX_ARGS_RESET);
    push_word(32'd0);
    send_frame(1'b1);
    push_word(32'd1);
    send_frame(1'b1);
    apply_limits(32'hFFFF_FFFF, MAX_ARGS_RESET);
    push_word(32'hFFFF_FFFF); push_word(32'd0);
    send_frame(1'b1);
    push_word(32'hFFFF_FFFF); push_word(32'd1); push_word(32'hFFFF_FFFF);
    send_frame(1'b1);
  endtask

  task automatic test_argument_count_checks();
    apply_limits(MAX_MSG_RESET, 21'd0);
    push_word(32'd4); push_word(32'd0);
    send_frame(1'b1);
    push_word(32'd8); push_word(32'd1);
    send_frame(1'b1);
    apply_limits(MAX_MSG_RESET, 21'd1048576);
    push_word(32'd100); push_word(32'hFFFF_FFFF);
    send_frame(1'b1);
    // largest count accepted, then abandoned
    push_word(32'd100); push_word(32'd1048576); push_word(32'd0);
    push_word(32'd2); push_byte(8'hFF); push_byte(8'h00);
    send_frame(1'b1);
    apply_limits(MAX_MSG_RESET, 21'd3);
    push_word(32'd19); push_word(32'd3);
    push_word(32'd0);
    push_word(32'd1); push_byte(8'hA5);
    push_word(32'd2); push_byte(8'h00); push_byte(8'hFF);
    send_frame(1'b1);
    push_word(32'd20); push_word(32'd4);
    send_frame(1'b0);
  endtask

  task automatic test_request_layouts();
    apply_limits(MAX_MSG_RESET, MAX_ARGS_RESET);
    push_word(32'd4); push_word(32'd0);
    send_frame(1'b1);
    push_word(32'd20); push_word(32'd3);
    push_word(32'd3); push_byte(8'hFF); push_byte(8'h00); push_byte(8'h80);
    push_word(32'd0);
    push_word(32'd1); push_byte(8'h7F);
    send_frame(1'b0);
    // body too short for the first argument length field
    push_word(32'd6); push_word(32'd1);
    send_frame(1'b0);
    // too little body left for the next length field
    push_word(32'd11); push_word(32'd2); push_word(32'd1); push_byte(8'h3C);
    send_frame(1'b1);
    // spare body bytes after the last argument
    push_word(32'd12); push_word(32'd1); push_word(32'd2); push_byte(8'h01); push_byte(8'h02);
    send_frame(1'b1);
    // argument longer than the rest of the body
    push_word(32'd10); push_word(32'd1); push_word(32'd3);
    send_frame(1'b1);
  endtask

  task automatic test_error_recovery();
    // drop bytes while the error holds
    repeat (6) push_byte(8'hFF);
    send_frame(1'b0);
    // reconnect in the middle of a request
    push_word(32'd12); push_word(32'd1); push_word(32'd4); push_byte(8'h11);
    send_frame(1'b1);
    push_word(32'd9); push_word(32'd1); push_word(32'd1); push_byte(8'h22);
    send_frame(1'b1);
    push_word(32'd4); push_word(32'd0);
    send_frame(1'b1);
  endtask

  task automatic send_random_request();
    int          roll;
    int          n;
    int          k;
    int          cut;
    mutation_t   kind;
    bit          nc;
    logic [31:0] lens[$];
    logic [31:0] len_f[$];
    logic [31:0] body;
    logic [31:0] count_f;
    roll = $urandom_range(0, 99);
    if (roll < 70)      kind = MUTATE_NONE;
    else if (roll < 76) kind = MUTATE_BODY_SHORT;
    else if (roll < 82) kind = MUTATE_BODY_LONG;
    else if (roll < 87) kind = MUTATE_COUNT;
    else if (roll < 92) kind = MUTATE_ARG_LEN;
    else if (roll < 96) kind = MUTATE_TRUNCATE;
    else                kind = MUTATE_NOISE;
    nc = (ph != PH_FRAME_LEN) || (word_pos != 2'd0) || ($urandom_range(0, 99) < 8);
    if (kind == MUTATE_NOISE) begin
      repeat ($urandom_range(1, 6)) push_byte($urandom_range(0, 255));
      send_frame($urandom_range(0, 1));
      return;
    end
    n    = $urandom_range(0, 4);
    body = 32'd4;
    for (int i = 0; i < n; i++) begin
      lens.insert(lens.size(), ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                           : $urandom_range(0, 8));
      body = body + 32'd4 + lens[i];
    end
    len_f   = lens;
    count_f = n;
    case (kind)
      MUTATE_BODY_SHORT: body = body - $urandom_range(1, 6);
      MUTATE_BODY_LONG:  body = body + $urandom_range(1, 6);
      MUTATE_COUNT: begin
        if (n != 0 && $urandom_range(0, 1))
          count_f = n - 1;
        else
          count_f = n + 1;
      end
      MUTATE_ARG_LEN: begin
        if (n != 0) begin
          k = $urandom_range(0, n - 1);
          if (len_f[k] != 0 && $urandom_range(0, 1))
            len_f[k] = len_f[k] - 1;
          else
            len_f[k] = len_f[k] + $urandom_range(1, 5);
        end
      end
      default: ;
    endcase
    push_word(body);
    push_word(count_f);
    for (int i = 0; i < n; i++) begin
      push_word(len_f[i]);
      repeat (lens[i]) push_byte($urandom_range(0, 255));
    end
    if (kind == MUTATE_TRUNCATE) begin
      cut = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > cut)
        frame_q.delete(frame_q.size() - 1);
    end
    send_frame(nc);
  endtask

  task automatic test_random_requests();
    int target;
    int round;
    int next_switch;
    target      = bytes_sent + 1550;
    round       = 0;
    next_switch = bytes_sent;
    while (bytes_sent < target) begin
      if (bytes_sent >= next_switch && target - bytes_sent >= 300) begin
        case (round % 6)
          0: apply_limits(32'd200, 21'd8);
          1: apply_limits(32'd40, 21'd2);
          2: apply_limits(32'hFFFF_FFFF, 21'd1048576);
          3: apply_limits(32'd24, 21'd5);
          4: apply_limits(MAX_MSG_RESET, MAX_ARGS_RESET);
          default: apply_limits(32'd64, 21'd1);
        endcase
        round++;
        next_switch = bytes_sent + 300;
      end
      if (target - bytes_sent < 300) begin
        feed_throttle = 1'b0;
        sink_throttle = 1'b0;
      end
      send_random_request();
    end
  endtask

  initial begin
    reset_parse();
    lim_msg  = MAX_MSG_RESET;
    lim_args = MAX_ARGS_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_register_access();
    test_frame_length_checks();
    test_argument_count_checks();
    test_request_layouts();
    test_error_recovery();
    test_random_requests();
    settle_parser();
    $display("%0d bytes in, %0d results checked, %0d message ends, %0d register writes",
             bytes_sent, results_checked, message_ends, cfg_writes);
    $display("limits at both extremes, all error codes, sticky errors and reconnects");
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout: %0d results still awaited", pending_events.size());
    $display("simulation failed");
    $finish;
  end

endmodule
